>>> rtl/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared sizes, codes and helpers of the symbol fixup engine.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int MEM_WORDS   = 262144;
  localparam int SYM_ENTRIES = 512;

  localparam int WORD_W  = 36;
  localparam int HALF_W  = 18;
  localparam int ADDR_W  = 18;
  localparam int NAME_W  = 32;
  localparam int TYPE_W  = 6;
  localparam int UCNT_W  = 10;
  localparam int MEM_AW  = $clog2(MEM_WORDS);
  localparam int SYM_AW  = $clog2(SYM_ENTRIES);
  localparam int CNT_W   = $clog2(SYM_ENTRIES + 1);
  localparam int STEP_W  = $clog2(MEM_WORDS + 1);
  localparam int ENTRY_W = 2 * WORD_W;

  localparam logic [ADDR_W:0]   MEM_LIMIT  = (ADDR_W + 1)'(MEM_WORDS);
  localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(MEM_WORDS);
  localparam logic [CNT_W-1:0]  SYM_LIMIT  = CNT_W'(SYM_ENTRIES);

  localparam logic [TYPE_W-1:0] TYPE_GLOBAL = 6'o04;
  localparam logic [TYPE_W-1:0] TYPE_HIDDEN = 6'o44;
  localparam logic [TYPE_W-1:0] TYPE_UNDEF  = 6'o60;

  typedef enum logic [1:0] {
    MODE_STORE = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MULTI = 2'd1,
    ST_FULL  = 2'd2,
    ST_LONG  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_SRCH,
    S_CMP,
    S_CRD,
    S_CWR,
    S_DONE
  } state_t;

  function automatic logic [TYPE_W-1:0] sym_type(input logic [WORD_W-1:0] name);
    return {name[WORD_W-1:WORD_W-4], 2'b00};
  endfunction

  function automatic logic is_global(input logic [TYPE_W-1:0] t);
    return (t == TYPE_GLOBAL) || (t == TYPE_HIDDEN);
  endfunction

  function automatic logic mem_hit(input logic [ADDR_W-1:0] a);
    return {1'b0, a} < MEM_LIMIT;
  endfunction

endpackage

>>> rtl/lsf_ram.sv
// ----------------------------------------------------------------------------
// lsf_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lsf_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/linker_symbol_fixup_engine.sv
// ----------------------------------------------------------------------------
// linker_symbol_fixup_engine
// Word memory and symbol table with global symbol chain fixup.
// ----------------------------------------------------------------------------
// The cmd channel carries one transaction per item: store a code word, read
// a word back, load one symbol (name and value word) or, in MODE_NONE, do
// nothing. The rsp channel returns one transaction per item with read data,
// status, the number of undefined table entries and a sticky error flag.
// The block works on one item at a time; cmd_stall is high while it is busy.
// A store writes its word on accept; a read waits on the registered read
// port; a symbol load searches the table (up to SYM_ENTRIES entries) and
// may then walk a chain (up to MEM_WORDS links). The search and the chain
// walk each use the single read port of their memory, one read and one
// compare or write-back for each table entry or chain link.
// The result sits in an output register; while rsp_stall holds it, a new
// item is still taken and worked on, and waits before its result is loaded.
// Reset clears the table count, the undefined count, the error flag and the
// output valid; memory and table contents are undefined until written.
// ----------------------------------------------------------------------------
module linker_symbol_fixup_engine
  import lsf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  logic [1:0]        mode,
  input  logic [ADDR_W-1:0] address,
  input  logic [WORD_W-1:0] code_word,
  input  logic [WORD_W-1:0] symbol_name,
  input  logic [WORD_W-1:0] symbol_value,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [WORD_W-1:0] read_data,
  output logic [1:0]        status,
  output logic [UCNT_W-1:0] undefined_count,
  output logic              error_seen
);

  state_t              state, state_next;
  logic [ADDR_W-1:0]   p, p_next;
  logic [HALF_W-1:0]   hw, hw_next;
  logic [STEP_W-1:0]   steps, steps_next;
  logic                resolve, resolve_next;
  logic                replace, replace_next;
  logic [CNT_W-1:0]    idx, idx_next;
  logic [WORD_W-1:0]   name_r, name_r_next;
  logic [WORD_W-1:0]   value_r, value_r_next;
  logic [WORD_W-1:0]   res_data, res_data_next;
  status_t             res_status, res_status_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [CNT_W-1:0]    undef, undef_next;
  logic                error_flag, error_flag_next;

  logic                mem_we;
  logic [MEM_AW-1:0]   mem_waddr, mem_raddr;
  logic [WORD_W-1:0]   mem_wdata, mem_rd;
  logic                tab_we;
  logic [SYM_AW-1:0]   tab_waddr;
  logic [ENTRY_W-1:0]  tab_wdata, tab_rd;

  logic                accept, out_free;
  logic [WORD_W-1:0]   tab_name, tab_val, word;
  logic [TYPE_W-1:0]   old_t, new_t;
  logic [HALF_W-1:0]   link;
  logic [STEP_W-1:0]   steps_inc;
  logic                match, last_entry, chain_go, cwr_finish;

  assign accept     = cmd_valid && !cmd_stall;
  assign cmd_stall  = (state != S_IDLE);
  assign out_free   = !rsp_valid || !rsp_stall;
  assign tab_name   = tab_rd[ENTRY_W-1:WORD_W];
  assign tab_val    = tab_rd[WORD_W-1:0];
  assign old_t      = sym_type(tab_name);
  assign new_t      = sym_type(name_r);
  assign match      = (tab_name[NAME_W-1:0] == name_r[NAME_W-1:0]);
  assign last_entry = ((idx + 1'b1) >= count);
  assign word       = mem_hit(p) ? mem_rd : '0;
  assign link       = word[HALF_W-1:0];
  assign steps_inc  = steps + 1'b1;

  assign chain_go = match && (((old_t == TYPE_UNDEF) &&
                               (is_global(new_t) || (new_t == TYPE_UNDEF))) ||
                              (is_global(old_t) && (new_t == TYPE_UNDEF)));

  always_comb begin
    if (resolve) begin
      cwr_finish = (link == '0) || (steps_inc >= STEP_LIMIT);
    end else begin
      cwr_finish = (link == '0) || (steps >= STEP_LIMIT);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_t'(mode))
            MODE_LOAD:  state_next = S_SRCH;
            MODE_READ:  state_next = S_RDWAIT;
            MODE_STORE,
            MODE_NONE:  state_next = S_DONE;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_RDWAIT: state_next = S_DONE;
      S_SRCH:   state_next = (idx >= count) ? S_DONE : S_CMP;
      S_CMP: begin
        if (chain_go) begin
          state_next = S_CRD;
        end else if (match || last_entry) begin
          state_next = (match) ? S_DONE : S_SRCH;
        end else begin
          state_next = S_SRCH;
        end
      end
      S_CRD:    state_next = S_CWR;
      S_CWR:    state_next = cwr_finish ? S_DONE : S_CRD;
      S_DONE:   state_next = out_free ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    p_next          = p;
    hw_next         = hw;
    steps_next      = steps;
    resolve_next    = resolve;
    replace_next    = replace;
    idx_next        = idx;
    name_r_next     = name_r;
    value_r_next    = value_r;
    res_data_next   = res_data;
    res_status_next = res_status;
    count_next      = count;
    undef_next      = undef;
    error_flag_next = error_flag;
    mem_we          = 1'b0;
    mem_waddr       = p[MEM_AW-1:0];
    mem_wdata       = {word[WORD_W-1:HALF_W], hw};
    mem_raddr       = p[MEM_AW-1:0];
    tab_we          = 1'b0;
    tab_waddr       = idx[SYM_AW-1:0];
    tab_wdata       = {name_r, value_r};
    unique case (state)
      S_IDLE: begin
        mem_raddr = address[MEM_AW-1:0];
        if (accept) begin
          p_next          = address;
          name_r_next     = symbol_name;
          value_r_next    = symbol_value;
          idx_next        = '0;
          res_data_next   = '0;
          res_status_next = ST_OK;
          if ((mode_t'(mode) == MODE_STORE) && mem_hit(address)) begin
            mem_we    = 1'b1;
            mem_waddr = address[MEM_AW-1:0];
            mem_wdata = code_word;
          end
        end
      end
      S_RDWAIT: res_data_next = word;
      S_SRCH: begin
        if (idx >= count) begin
          if (count >= SYM_LIMIT) begin
            res_status_next = ST_FULL;
          end else begin
            tab_we     = 1'b1;
            tab_waddr  = count[SYM_AW-1:0];
            count_next = count + 1'b1;
            if (new_t == TYPE_UNDEF) begin
              undef_next = undef + 1'b1;
            end
          end
        end
      end
      S_CMP: begin
        steps_next = '0;
        if (!match) begin
          idx_next = idx + 1'b1;
        end else if (old_t == TYPE_UNDEF) begin
          p_next       = tab_val[ADDR_W-1:0];
          hw_next      = value_r[HALF_W-1:0];
          resolve_next = is_global(new_t);
          replace_next = is_global(new_t);
        end else if (is_global(old_t)) begin
          if (is_global(new_t)) begin
            res_status_next = ((new_t == old_t) && (value_r == tab_val)) ? ST_OK : ST_MULTI;
          end else begin
            p_next       = value_r[ADDR_W-1:0];
            hw_next      = tab_val[HALF_W-1:0];
            resolve_next = 1'b1;
            replace_next = 1'b0;
          end
        end
      end
      S_CWR: begin
        if (resolve) begin
          mem_we     = mem_hit(p);
          p_next     = link;
          steps_next = steps_inc;
          if ((link != '0) && (steps_inc >= STEP_LIMIT)) begin
            res_status_next = ST_LONG;
          end
          if (cwr_finish && replace) begin
            tab_we = 1'b1;
            if (undef != '0) begin
              undef_next = undef - 1'b1;
            end
          end
        end else if (link != '0) begin
          if (steps >= STEP_LIMIT) begin
            res_status_next = ST_LONG;
          end else begin
            p_next     = link;
            steps_next = steps_inc;
          end
        end else begin
          mem_we = mem_hit(p);
        end
      end
      S_DONE: begin
        if (out_free && (res_status != ST_OK)) begin
          error_flag_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      undef      <= '0;
      error_flag <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      undef      <= undef_next;
      error_flag <= error_flag_next;
      if ((state == S_DONE) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p          <= p_next;
    hw         <= hw_next;
    steps      <= steps_next;
    resolve    <= resolve_next;
    replace    <= replace_next;
    idx        <= idx_next;
    name_r     <= name_r_next;
    value_r    <= value_r_next;
    res_data   <= res_data_next;
    res_status <= res_status_next;
    if ((state == S_DONE) && out_free) begin
      read_data       <= res_data;
      status          <= res_status;
      undefined_count <= UCNT_W'(undef);
      error_seen      <= error_flag_next;
    end
  end

  lsf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rd)
  );

  lsf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYM_ENTRIES)
  ) u_tab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (idx[SYM_AW-1:0]),
    .rdata (tab_rd)
  );

endmodule

>>> rtl/lsf_checker.sv
// ----------------------------------------------------------------------------
// lsf_checker
// Port-level checks of the symbol fixup engine, bound to the top level.
// ----------------------------------------------------------------------------
module lsf_checker
  import lsf_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input logic [WORD_W-1:0] read_data,
  input logic [1:0]        status,
  input logic [UCNT_W-1:0] undefined_count,
  input logic              error_seen
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data) && $stable(status))
    else $error("stalled rsp transaction changed");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && error_seen |=> error_seen)
    else $error("error flag cleared");

  a_err_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_OK) |-> error_seen)
    else $error("error status without error flag");

  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (read_data != '0) |-> (status == ST_OK))
    else $error("read data with error status");

  a_undef_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ({1'b0, undefined_count} <= (UCNT_W + 1)'(SYM_ENTRIES)))
    else $error("undefined count above table size");

endmodule

bind linker_symbol_fixup_engine lsf_checker u_lsf_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp_valid),
  .rsp_stall       (rsp_stall),
  .read_data       (read_data),
  .status          (status),
  .undefined_count (undefined_count),
  .error_seen      (error_seen)
);

>>> bench/linker_symbol_fixup_engine_tb.sv
// ----------------------------------------------------------------------------
// linker_symbol_fixup_engine_tb
// Self-checking bench for the symbol fixup engine.
// A scoreboard mirrors the word memory and the symbol table, predicts one
// result per command transaction and checks every response in order. The
// run starts with directed cases: stores, reads, chain extension,
// resolution both ways, redefinitions, the zero chain head and a long chain.
// Random traffic with idle bursts on both channels follows. The table is
// then filled to overflow with no idling.
// ----------------------------------------------------------------------------
module linker_symbol_fixup_engine_tb;
  import lsf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [WORD_W-1:0] data;
    status_t           st;
    logic [UCNT_W-1:0] ucnt;
    logic              err;
  } fixup_result_t;

  class fixup_scoreboard;
    bit [WORD_W-1:0] words [bit [ADDR_W-1:0]];
    bit [WORD_W-1:0] sym_name [SYM_ENTRIES];
    bit [WORD_W-1:0] sym_val [SYM_ENTRIES];
    int unsigned     sym_count;
    int unsigned     undef_total;
    bit              err_flag;
    int unsigned     fails;
    int unsigned     n_store, n_load, n_read, n_other;
    int unsigned     n_status [4];
    fixup_result_t   pending [$];

    function bit [WORD_W-1:0] rd(bit [ADDR_W-1:0] a);
      return words.exists(a) ? words[a] : '0;
    endfunction

    function void put_right(bit [ADDR_W-1:0] a, bit [HALF_W-1:0] hw);
      bit [WORD_W-1:0] w;
      w = rd(a);
      words[a] = {w[WORD_W-1:HALF_W], hw};
    endfunction

    function bit [TYPE_W-1:0] tp(bit [WORD_W-1:0] n);
      return {n[35:32], 2'b00};
    endfunction

    function bit glob(bit [TYPE_W-1:0] t);
      return t == TYPE_GLOBAL || t == TYPE_HIDDEN;
    endfunction

    function int find(bit [WORD_W-1:0] n);
      for (int i = 0; i < sym_count; i++)
        if (sym_name[i][31:0] == n[31:0]) return i;
      return -1;
    endfunction

    function status_t extend(bit [ADDR_W-1:0] p, bit [HALF_W-1:0] hw);
      int unsigned steps;
      bit [WORD_W-1:0] w;
      steps = 0;
      w = rd(p);
      while (w[HALF_W-1:0] != 0) begin
        if (steps >= MEM_WORDS) return ST_LONG;
        p = w[HALF_W-1:0];
        w = rd(p);
        steps++;
      end
      put_right(p, hw);
      return ST_OK;
    endfunction

    function status_t resolve(bit [ADDR_W-1:0] p, bit [HALF_W-1:0] hw);
      int unsigned steps;
      bit [WORD_W-1:0] w;
      steps = 0;
      do begin
        if (steps >= MEM_WORDS) return ST_LONG;
        w = rd(p);
        put_right(p, hw);
        p = w[HALF_W-1:0];
        steps++;
      end while (w[HALF_W-1:0] != 0);
      return ST_OK;
    endfunction

    function status_t load(bit [WORD_W-1:0] n, bit [WORD_W-1:0] v);
      int i;
      bit [TYPE_W-1:0] nt, ot;
      status_t st;
      nt = tp(n);
      i = find(n);
      if (i < 0) begin
        if (sym_count >= SYM_ENTRIES) return ST_FULL;
        sym_name[sym_count] = n;
        sym_val[sym_count] = v;
        sym_count++;
        if (nt == TYPE_UNDEF) undef_total++;
        return ST_OK;
      end
      ot = tp(sym_name[i]);
      if (ot == TYPE_UNDEF) begin
        if (glob(nt)) begin
          st = resolve(sym_val[i][HALF_W-1:0], v[HALF_W-1:0]);
          sym_name[i] = n;
          sym_val[i] = v;
          if (undef_total > 0) undef_total--;
          return st;
        end
        if (nt == TYPE_UNDEF) return extend(sym_val[i][HALF_W-1:0], v[HALF_W-1:0]);
      end else if (glob(ot)) begin
        if (glob(nt)) return (nt == ot && v == sym_val[i]) ? ST_OK : ST_MULTI;
        if (nt == TYPE_UNDEF) return resolve(v[HALF_W-1:0], sym_val[i][HALF_W-1:0]);
      end
      return ST_OK;
    endfunction

    // True when a symbol load walks only written words and ends quickly.
    function bit safe(bit [WORD_W-1:0] n, bit [WORD_W-1:0] v);
      int i;
      bit [TYPE_W-1:0] nt, ot;
      bit [ADDR_W-1:0] p;
      nt = tp(n);
      i = find(n);
      if (i < 0) return 1;
      ot = tp(sym_name[i]);
      if (ot == TYPE_UNDEF && (glob(nt) || nt == TYPE_UNDEF)) p = sym_val[i][HALF_W-1:0];
      else if (glob(ot) && nt == TYPE_UNDEF) p = v[HALF_W-1:0];
      else return 1;
      for (int s = 0; s < 64; s++) begin
        if (!words.exists(p)) return 0;
        if (words[p][HALF_W-1:0] == 0) return 1;
        p = words[p][HALF_W-1:0];
      end
      return 0;
    endfunction

    function bit lookup(bit [WORD_W-1:0] n, output bit [WORD_W-1:0] fn,
                        output bit [WORD_W-1:0] fv);
      int i;
      i = find(n);
      if (i < 0) return 0;
      fn = sym_name[i];
      fv = sym_val[i];
      return 1;
    endfunction

    function void note(mode_t m, bit [ADDR_W-1:0] a, bit [WORD_W-1:0] cw,
                       bit [WORD_W-1:0] n, bit [WORD_W-1:0] v);
      fixup_result_t r;
      r.data = '0;
      r.st = ST_OK;
      case (m)
        MODE_STORE: begin
          words[a] = cw;
          n_store++;
        end
        MODE_LOAD: begin
          r.st = load(n, v);
          n_load++;
        end
        MODE_READ: begin
          r.data = rd(a);
          n_read++;
        end
        default: n_other++;
      endcase
      if (r.st != ST_OK) err_flag = 1;
      n_status[r.st]++;
      r.ucnt = undef_total[UCNT_W-1:0];
      r.err = err_flag;
      pending.push_back(r);
    endfunction

    function void check(logic [WORD_W-1:0] d, logic [1:0] s, logic [UCNT_W-1:0] u,
                        logic e);
      fixup_result_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response transaction", $realtime);
        fails++;
        return;
      end
      x = pending.pop_front();
      if (d !== x.data) begin
        $display("%0t: read_data expected %o actual %o", $realtime, x.data, d);
        fails++;
      end
      if (s !== x.st) begin
        $display("%0t: status expected %0d actual %0d", $realtime, x.st, s);
        fails++;
      end
      if (u !== x.ucnt) begin
        $display("%0t: undefined_count expected %0d actual %0d", $realtime, x.ucnt, u);
        fails++;
      end
      if (e !== x.err) begin
        $display("%0t: error_seen expected %0d actual %0d", $realtime, x.err, e);
        fails++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cmd_valid;
  logic              cmd_stall;
  logic [1:0]        mode;
  logic [ADDR_W-1:0] address;
  logic [WORD_W-1:0] code_word;
  logic [WORD_W-1:0] symbol_name;
  logic [WORD_W-1:0] symbol_value;
  logic              rsp_valid;
  logic              rsp_stall;
  logic [WORD_W-1:0] read_data;
  logic [1:0]        status;
  logic [UCNT_W-1:0] undefined_count;
  logic              error_seen;

  fixup_scoreboard   sb;
  bit                quiet;
  bit [ADDR_W-1:0]   pool [$];
  bit [31:0]         names [24];

  linker_symbol_fixup_engine dut (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall)
      sb.check(read_data, status, undefined_count, error_seen);
  end

  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 6) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      rsp_stall <= 1'b0;
    end
  end

  task automatic send(mode_t m, bit [ADDR_W-1:0] a, bit [WORD_W-1:0] cw,
                      bit [WORD_W-1:0] n, bit [WORD_W-1:0] v);
    mode <= m;
    address <= a;
    code_word <= cw;
    symbol_name <= n;
    symbol_value <= v;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    sb.note(m, a, cw, n, v);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic store(bit [ADDR_W-1:0] a, bit [WORD_W-1:0] w);
    send(MODE_STORE, a, w, WORD_W'({$urandom, $urandom}), WORD_W'({$urandom, $urandom}));
    pool.push_back(a);
  endtask

  task automatic read(bit [ADDR_W-1:0] a);
    send(MODE_READ, a, WORD_W'({$urandom, $urandom}), WORD_W'({$urandom, $urandom}),
         WORD_W'({$urandom, $urandom}));
  endtask

  task automatic symbol(bit [WORD_W-1:0] n, bit [WORD_W-1:0] v);
    send(MODE_LOAD, ADDR_W'($urandom), WORD_W'({$urandom, $urandom}), n, v);
  endtask

  function automatic bit [ADDR_W-1:0] pick();
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  task automatic random_item();
    bit [ADDR_W-1:0] a;
    bit [WORD_W-1:0] n, v, fn, fv;
    bit [3:0]        t;
    int              k;
    k = $urandom_range(0, 19);
    if (k < 5) begin
      a = ($urandom_range(0, 2) == 0) ? ADDR_W'($urandom) : pick();
      do v[HALF_W-1:0] = pick(); while (v[HALF_W-1:0] == a && a != 0);
      v[WORD_W-1:HALF_W] = HALF_W'($urandom);
      store(a, v);
    end else if (k < 9) begin
      read(pick());
    end else if (k == 9) begin
      send(MODE_NONE, ADDR_W'($urandom), WORD_W'({$urandom, $urandom}),
           WORD_W'({$urandom, $urandom}), WORD_W'({$urandom, $urandom}));
    end else begin
      case ($urandom_range(0, 5))
        0: t = 4'b0001;
        1: t = 4'b1001;
        2, 3: t = 4'b1100;
        default: t = 4'($urandom);
      endcase
      n = {t, names[$urandom_range(0, 23)]};
      v = {HALF_W'($urandom), pick()};
      if ($urandom_range(0, 3) == 0 && sb.lookup(n, fn, fv)) begin
        n = fn;
        v = fv;
      end
      if (sb.safe(n, v)) symbol(n, v);
      else read(pick());
    end
  endtask

  initial begin
    bit [WORD_W-1:0] nm;
    sb = new();
    quiet = 0;
    rst = 1'b1;
    cmd_valid = 1'b0;
    mode = '0;
    address = '0;
    code_word = '0;
    symbol_name = '0;
    symbol_value = '0;
    foreach (names[i]) names[i] = $urandom;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    store(18'h00000, '0);
    store(18'h3ffff, {18'h3ffff, 18'h00000});
    store(18'h2aaaa, {18'h15555, 18'h00000});
    store(18'h15555, {18'h2aaaa, 18'h3ffff});
    read(18'h3ffff);
    read(18'h00000);
    send(MODE_NONE, '1, '1, '1, '1);
    symbol({4'b1100, names[0]}, {18'h0, 18'h15555});
    symbol({4'b1100, names[0]}, {18'h0, 18'h2aaaa});
    read(18'h3ffff);
    symbol({4'b0001, names[0]}, {18'h3ffff, 18'h00000});
    read(18'h15555);
    symbol({4'b0001, names[0]}, {18'h3ffff, 18'h00000});
    symbol({4'b1001, names[0]}, {18'h3ffff, 18'h00000});
    symbol({4'b1100, names[0]}, {18'h0, 18'h15555});
    symbol({4'b1100, names[1]}, '0);
    symbol({4'b1001, names[1]}, {18'h12345, 18'h00000});
    read(18'h00000);
    symbol({4'b0000, names[2]}, '1);
    symbol({4'b0001, names[2]}, '0);

    // self-looped word: the resolution below runs the walk to its step limit
    store(18'h00100, {18'h0, 18'h00100});
    symbol({4'b1100, names[3]}, {18'h0, 18'h00100});
    drain();
    symbol({4'b0001, names[3]}, {18'h0, 18'h00100});
    read(18'h00100);

    repeat (300) random_item();
    drain();

    quiet = 1;
    for (int i = 0; i < 130; i++) random_item();
    while (sb.sym_count < SYM_ENTRIES) begin
      nm = {4'b1100, 32'h8000_0000 | 32'(sb.sym_count)};
      if (sb.find(nm) < 0) symbol(nm, '0);
      else symbol({4'b1100, 32'h4000_0000 | 32'(sb.sym_count)}, '0);
    end
    repeat (3) symbol({4'b0001, 32'h7fff_fff0}, '0);
    read(pick());
    drain();
    repeat (50) @(posedge clk);

    $display("Run covered %0d stores, %0d symbol loads, %0d reads, %0d unused-mode items;",
             sb.n_store, sb.n_load, sb.n_read, sb.n_other);
    $display("statuses seen: ok %0d, multiple %0d, table full %0d, chain too long %0d",
             sb.n_status[0], sb.n_status[1], sb.n_status[2], sb.n_status[3]);
    if (sb.fails == 0 && sb.pending.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
